[rtl/bitmap_frame_allocator_assert.svh]
// assertion macros for the bitmap frame allocator
// expects clk and arst_n in the scope of the including module
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bfa_pkg.sv]
// shared types and constants of the bitmap frame allocator
// no dependencies
package bfa_pkg;

	localparam int FRAME_COUNT_DEF = 1024;
	localparam int REG_W = 11;
	localparam int REG_IDX_W = 1;
	localparam int KIND_W = 2;
	localparam int FRAME_IN_W = 13;
	localparam int GRANT_W = 10;
	localparam int WORD_BITS = 32;
	localparam int WORD_SHIFT = 5;

	localparam logic [REG_W-1:0] KERNEL_FIRST_RST = 11'd16;
	localparam logic [REG_W-1:0] KERNEL_END_RST = 11'd256;

	// fixed reserved areas
	localparam int GDT_FRAME = 'h90;
	localparam int BIOS_FIRST = 'hA0;
	localparam int BIOS_END = 'h100;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INIT  = 2'd2
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KERNEL_FIRST = 1'b0,
		REG_KERNEL_END   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_PICK,
		ST_A_CHECK,
		ST_F_WRITE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [FRAME_IN_W-1:0] frame;
	} in_t;

	typedef struct packed {
		logic [GRANT_W-1:0] granted_frame;
		logic               found;
	} out_t;

endpackage

[rtl/bfa_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bfa_summary.sv]
// one flag per bitmap word telling whether the word holds any free frame,
// and a search for the lowest flagged word at or above the start word; uses bfa_pkg
module bfa_summary #(
	parameter int DEPTH = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            upd_en,
	input  logic [$clog2(DEPTH)-1:0]                        upd_idx,
	input  logic                                            upd_free,
	input  logic [bfa_pkg::REG_W-bfa_pkg::WORD_SHIFT-1:0]  start_word,
	input  logic                                            skip_start,
	output logic                                            hit,
	output logic [$clog2(DEPTH)-1:0]                        hit_idx
);

	localparam int AW = $clog2(DEPTH);

	logic [DEPTH-1:0] free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (upd_en) begin
			free_q[upd_idx] <= upd_free;
		end
	end

	// lowest flagged word above the start word, or the start word itself unless skipped
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int w = DEPTH - 1; w >= 0; w--) begin
			if (free_q[w] && ((w > int'(start_word)) ||
					(w == int'(start_word) && !skip_start))) begin
				hit = 1'b1;
				hit_idx = AW'(w);
			end
		end
	end

endmodule

[rtl/bitmap_frame_allocator.sv]
// Bitmap frame allocator: one used/free bit per frame, kept in a word memory of
// 32 frames per word with a flag per word that says whether it holds a free frame.
// An allocate request searches the word flags and reads the word, then picks the
// lowest free bit and writes the word back; when the first flagged word is the one
// holding kernel_end and its only free bits lie below kernel_end, a second search
// and read follow. A free request reads the word and writes it back; a free of a
// frame at or beyond FRAME_COUNT or an unused kind is dropped. Alloc and free
// requests are read-modify-writes on the word memory, so one runs at a time.
// A reinitialize request and reset both run a fill pass over all words, one word a
// cycle, during which in_stall is high; the pass uses the kernel range registers as
// they stood when it started. Results wait in an output register, so a request may
// be taken while an earlier result is still stalled.
module bitmap_frame_allocator #(
	parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bfa_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bfa_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [bfa_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [bfa_pkg::REG_W-1:0]       cfg_data
);

	`include "bitmap_frame_allocator_assert.svh"

	localparam int WB = bfa_pkg::WORD_BITS;
	localparam int WS = bfa_pkg::WORD_SHIFT;
	localparam int DEPTH = (FRAME_COUNT + WB - 1) / WB;
	localparam int AW = $clog2(DEPTH);
	localparam int FW = AW + WS;
	localparam int SW = bfa_pkg::REG_W - WS;
	localparam int CMP_W = ((FW > bfa_pkg::FRAME_IN_W) ? FW : bfa_pkg::FRAME_IN_W) + 1;
	localparam logic [CMP_W-1:0] FC_C = CMP_W'(FRAME_COUNT);
	localparam logic [CMP_W-1:0] GDT_C = CMP_W'(bfa_pkg::GDT_FRAME);
	localparam logic [CMP_W-1:0] BIOS_FIRST_C = CMP_W'(bfa_pkg::BIOS_FIRST);
	localparam logic [CMP_W-1:0] BIOS_END_C = CMP_W'(bfa_pkg::BIOS_END);
	localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

	bfa_pkg::state_t state_q, state_d;

	logic [bfa_pkg::REG_W-1:0] kfirst_q, kend_q;
	logic [bfa_pkg::REG_W-1:0] ini_first_q, ini_end_q;
	logic [AW-1:0]             idx_q;
	logic [AW-1:0]             op_word_q;
	logic [WS-1:0]             op_bit_q;
	logic                      hit_q;
	logic                      out_valid_q;
	bfa_pkg::out_t             out_q, out_d;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [WB-1:0] ram_wdata, ram_rdata;

	logic          sum_upd_en, sum_upd_free, sum_hit, sum_skip;
	logic [AW-1:0] sum_upd_idx, sum_hit_idx;

	logic [WB-1:0] init_word;
	logic [WB-1:0] low_mask, free_bits, set_word;
	logic [WS-1:0] pick_bit;
	logic [FW-1:0] pick_frame;
	logic          any_free, grant, out_free, out_load, take_item, free_in_range;
	logic [SW-1:0] start_word;

	bfa_ram #(
		.WIDTH(WB),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bfa_summary #(
		.DEPTH(DEPTH)
	) u_summary (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (sum_upd_en),
		.upd_idx   (sum_upd_idx),
		.upd_free  (sum_upd_free),
		.start_word(start_word),
		.skip_start(sum_skip),
		.hit       (sum_hit),
		.hit_idx   (sum_hit_idx)
	);

	assign start_word = kend_q[bfa_pkg::REG_W-1:WS];
	assign sum_skip = (state_q == bfa_pkg::ST_A_PICK);
	assign out_free = !out_valid_q || !out_stall;
	assign take_item = in_valid && !in_stall;
	assign free_in_range = CMP_W'(in_data.frame) < FC_C;

	// initial contents of the word being filled
	always_comb begin
		logic [CMP_W-1:0] f;
		for (int b = 0; b < WB; b++) begin
			f = CMP_W'({idx_q, WS'(b)});
			init_word[b] = (f >= CMP_W'(ini_first_q) && f < CMP_W'(ini_end_q)) ||
				(f == GDT_C) || (f >= BIOS_FIRST_C && f < BIOS_END_C) || (f >= FC_C);
		end
	end

	// free bits of the read word, ignoring those below kernel_end in its own word
	always_comb begin
		if (CMP_W'(op_word_q) == CMP_W'(start_word)) begin
			low_mask = {WB{1'b1}} << kend_q[WS-1:0];
		end else begin
			low_mask = {WB{1'b1}};
		end
		free_bits = ~ram_rdata & low_mask;
		any_free = |free_bits;
		pick_bit = '0;
		for (int b = WB - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				pick_bit = WS'(b);
			end
		end
		set_word = ram_rdata | (WB'(1) << pick_bit);
		pick_frame = {op_word_q, pick_bit};
		grant = hit_q && any_free;
	end

	always_comb begin
		state_d = state_q;
		in_stall = (state_q != bfa_pkg::ST_IDLE);
		ram_we = 1'b0;
		ram_waddr = op_word_q;
		ram_wdata = set_word;
		ram_re = 1'b0;
		ram_raddr = sum_hit_idx;
		sum_upd_en = 1'b0;
		sum_upd_idx = op_word_q;
		sum_upd_free = |(~set_word);
		out_load = 1'b0;
		out_d.found = grant;
		out_d.granted_frame = grant ? bfa_pkg::GRANT_W'(pick_frame) : '0;
		case (state_q)
			bfa_pkg::ST_INIT: begin
				ram_we = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = init_word;
				sum_upd_en = 1'b1;
				sum_upd_idx = idx_q;
				sum_upd_free = |(~init_word);
				if (idx_q == LAST_WORD) begin
					state_d = bfa_pkg::ST_IDLE;
				end
			end
			bfa_pkg::ST_IDLE: begin
				if (take_item) begin
					case (in_data.kind)
						bfa_pkg::KIND_ALLOC: begin
							ram_re = 1'b1;
							state_d = bfa_pkg::ST_A_CHECK;
						end
						bfa_pkg::KIND_FREE: begin
							if (free_in_range) begin
								ram_re = 1'b1;
								ram_raddr = in_data.frame[WS +: AW];
								state_d = bfa_pkg::ST_F_WRITE;
							end
						end
						bfa_pkg::KIND_INIT: begin
							state_d = bfa_pkg::ST_INIT;
						end
						default: begin
						end
					endcase
				end
			end
			bfa_pkg::ST_A_PICK: begin
				ram_re = 1'b1;
				state_d = bfa_pkg::ST_A_CHECK;
			end
			bfa_pkg::ST_A_CHECK: begin
				if (hit_q && !any_free) begin
					// start word only had free frames below kernel_end
					state_d = bfa_pkg::ST_A_PICK;
				end else if (out_free) begin
					out_load = 1'b1;
					ram_we = grant;
					sum_upd_en = grant;
					state_d = bfa_pkg::ST_IDLE;
				end
			end
			bfa_pkg::ST_F_WRITE: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata & ~(WB'(1) << op_bit_q);
				sum_upd_en = 1'b1;
				sum_upd_free = 1'b1;
				state_d = bfa_pkg::ST_IDLE;
			end
			default: begin
				state_d = bfa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::ST_INIT;
			kfirst_q <= bfa_pkg::KERNEL_FIRST_RST;
			kend_q <= bfa_pkg::KERNEL_END_RST;
			ini_first_q <= bfa_pkg::KERNEL_FIRST_RST;
			ini_end_q <= bfa_pkg::KERNEL_END_RST;
			idx_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					bfa_pkg::REG_KERNEL_FIRST: kfirst_q <= cfg_data;
					bfa_pkg::REG_KERNEL_END: kend_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == bfa_pkg::ST_INIT) begin
				idx_q <= idx_q + AW'(1);
			end else if (state_d == bfa_pkg::ST_INIT) begin
				// snapshot the kernel range for the whole fill pass
				idx_q <= '0;
				ini_first_q <= kfirst_q;
				ini_end_q <= kend_q;
			end
			if (ram_re && state_d == bfa_pkg::ST_A_CHECK) begin
				hit_q <= sum_hit;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			op_word_q <= ram_raddr;
			op_bit_q <= in_data.frame[WS-1:0];
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`BFA_ASSERT_IMP(a_fill_stalls, state_q == bfa_pkg::ST_INIT, in_stall, "request taken during fill pass")
	`BFA_ASSERT_IMP(a_port_exclusive, ram_we, !ram_re, "word memory read and written in one cycle")
	`BFA_ASSERT_IMP(a_grant_above_kernel, out_load && grant, CMP_W'(pick_frame) >= CMP_W'(kend_q), "frame below kernel_end granted")
	`BFA_ASSERT_NXT(a_read_consumed, ram_re, state_q == bfa_pkg::ST_A_CHECK || state_q == bfa_pkg::ST_F_WRITE, "word read without a consumer")

endmodule
